// ----- hdl/ths_pkg.sv -----
// Shared types, constants and fixed-point helpers for the tide harmonic synthesis unit.
package ths_pkg;

  localparam int WAVE_SLOTS_DEF = 16;
  localparam int MAX_DEGREE_DEF = 7;

  localparam int IN_DATA_W  = 200;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_W      = 5;
  localparam int SUM_W      = 48;

  typedef enum logic [1:0] {
    FUNC_LOAD_COEF = 2'd0,
    FUNC_SET_MULT  = 2'd1,
    FUNC_SET_PHASE = 2'd2,
    FUNC_EVALUATE  = 2'd3
  } func_t;

  localparam logic [2:0] NUM_ARGS = 3'd6;

  // Sine polynomial coefficients, Q30, index 0 is the linear term.
  function automatic logic signed [33:0] sin_coef(input logic [2:0] idx);
    logic signed [33:0] c;
    case (idx)
      3'd0:    c = 34'sd1686629713;
      3'd1:    c = -34'sd693598668;
      3'd2:    c = 34'sd85569306;
      3'd3:    c = -34'sd5026995;
      3'd4:    c = 34'sd172272;
      3'd5:    c = -34'sd3864;
      default: c = 34'sd0;
    endcase
    return c;
  endfunction

  // Cosine polynomial coefficients, Q30, index 0 is the constant term.
  function automatic logic signed [33:0] cos_coef(input logic [2:0] idx);
    logic signed [33:0] c;
    case (idx)
      3'd0:    c = 34'sd1073741824;
      3'd1:    c = -34'sd1324675879;
      3'd2:    c = 34'sd272375560;
      3'd3:    c = -34'sd22401992;
      3'd4:    c = 34'sd987048;
      3'd5:    c = -34'sd27060;
      3'd6:    c = 34'sd506;
      default: c = 34'sd0;
    endcase
    return c;
  endfunction

  // Divide a product by 2^30, truncating toward zero.
  function automatic logic signed [33:0] q30_trunc(input logic signed [65:0] p);
    logic signed [65:0] b;
    b = p + (p[65] ? 66'sd1073741823 : 66'sd0);
    return b[63:30];
  endfunction

  // Clamp to [-1.0, 1.0] in Q30.
  function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate to the signed 48-bit range.
  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'sd140737488355327) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < -50'sd140737488355328) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/ths_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ths_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/tide_harmonic_synthesis_unit.sv -----
// Tide harmonic synthesis unit: top level with sequencer and shared multiplier.
// Keeps a table of WAVE_SLOTS tidal waves, each with six signed Doodson multipliers
// and prograde/retrograde cosine and sine coefficients for every degree and order up
// to MAX_DEGREE, plus six fundamental argument phases. An input transfer either loads
// coefficients (func 0), sets a wave's multipliers (func 1), sets an argument phase
// (func 2) or evaluates (func 3). Loads produce nothing. An evaluation first forms
// each wave's phase and its sine and cosine (fixed polynomials, Horner form), then
// emits (MAX_DEGREE+1)^2 results, degree major, order minor, with tlast on the
// final one. Every product goes through one shared 34x32 multiplier with a register
// behind it, so the cost is set by that unit: the phase and trig work for each used
// wave comes first, then each result is summed over the used waves and handed over.
// One item is worked on at a time and s_tready is low meanwhile; the result
// register lets the sequencer move on while a result waits to be taken. After
// reset the coefficient and multiplier memories are cleared by a sweep over all
// WAVE_SLOTS*(MAX_DEGREE+1)^2 addresses (1024 by default) before the first transfer
// is taken; configuration writes are taken at any time.
module tide_harmonic_synthesis_unit #(
  parameter int WAVE_SLOTS = ths_pkg::WAVE_SLOTS_DEF,
  parameter int MAX_DEGREE = ths_pkg::MAX_DEGREE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: waves_in_use
  input  logic                            cfg_wr_en,
  input  logic [ths_pkg::CFG_W-1:0]       cfg_wr_data,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata from bit 0: wave[3:0], degree[6:4], order[9:7], cos_plus[41:10],
  // sin_plus[73:42], cos_minus[105:74], sin_minus[137:106],
  // multipliers_packed[161:138], angle_index[164:162], angle[196:165], zero pad
  input  logic [ths_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: func[1:0]
  input  logic [ths_pkg::IN_USER_W-1:0]   s_tuser,
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata from bit 0: out_degree[2:0], out_order[5:3], cnm_sum[53:6],
  // snm_sum[101:54], zero pad
  output logic [ths_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);
  import ths_pkg::*;

  localparam int NSIDE   = MAX_DEGREE + 1;
  localparam int NTERMS  = NSIDE * NSIDE;
  localparam int CDEPTH  = WAVE_SLOTS * NTERMS;
  localparam int CA_W    = $clog2(CDEPTH);
  localparam int WIDX_W  = WAVE_SLOTS > 1 ? $clog2(WAVE_SLOTS) : 1;
  localparam int WCNT_W  = $clog2(WAVE_SLOTS + 1);

  // Step numbers within the phase, trig and accumulation sequences
  localparam logic [4:0] TH_LAST   = 5'd8;
  localparam logic [4:0] TS_Y      = 5'd1;
  localparam logic [4:0] TS_SIN_X  = 5'd12;
  localparam logic [4:0] TS_SIN_END= 5'd13;
  localparam logic [4:0] TS_STORE  = 5'd26;
  localparam logic [4:0] MS_LOAD   = 5'd1;
  localparam logic [4:0] MS_P0     = 5'd2;
  localparam logic [4:0] MS_P1     = 5'd3;
  localparam logic [4:0] MS_P2     = 5'd4;
  localparam logic [4:0] MS_P3     = 5'd5;
  localparam logic [4:0] MS_SSUM   = 5'd6;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_THETA = 6'b000100,
    S_TRIG  = 6'b001000,
    S_MAC   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;

  // Input fields
  logic [3:0]         in_wave;
  logic [2:0]         in_degree, in_order, in_angle_index;
  logic [31:0]        in_cos_plus, in_sin_plus, in_cos_minus, in_sin_minus, in_angle;
  logic [23:0]        in_mult;
  func_t              in_func;

  assign in_wave        = s_tdata[3:0];
  assign in_degree      = s_tdata[6:4];
  assign in_order       = s_tdata[9:7];
  assign in_cos_plus    = s_tdata[41:10];
  assign in_sin_plus    = s_tdata[73:42];
  assign in_cos_minus   = s_tdata[105:74];
  assign in_sin_minus   = s_tdata[137:106];
  assign in_mult        = s_tdata[161:138];
  assign in_angle_index = s_tdata[164:162];
  assign in_angle       = s_tdata[196:165];
  assign in_func        = func_t'(s_tuser);

  logic s_xfer;
  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;

  // Configuration and argument phases
  logic [CFG_W-1:0] waves_in_use;
  logic [31:0]      phases [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      waves_in_use <= '0;
    end else if (cfg_wr_en) begin
      waves_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        phases[i] <= '0;
      end
    end else if (s_xfer && in_func == FUNC_SET_PHASE && in_angle_index < NUM_ARGS) begin
      phases[in_angle_index] <= in_angle;
    end
  end

  // Sequencer registers
  logic [CA_W-1:0]    clr_addr;
  logic [4:0]         step;
  logic [WCNT_W-1:0]  w_cnt, used_cnt;
  logic [2:0]         n_idx, m_idx;
  logic [23:0]        mult_q;
  logic [31:0]        theta;
  logic [31:0]        y_q;
  logic signed [33:0] acc;
  logic signed [31:0] sin_q;
  logic signed [65:0] prod;
  logic signed [32:0] cpm, spm, sdf, cdf;
  logic signed [31:0] cn_q, sn_q;
  logic signed [33:0] part;
  logic signed [47:0] csum, ssum;

  logic [WIDX_W-1:0]  w_idx;
  assign w_idx = w_cnt[WIDX_W-1:0];

  // Wave table sanity checks on writes
  logic [7:0] wave_ext;
  logic       wave_ok, coef_ok;
  assign wave_ext = 8'(in_wave);
  assign wave_ok  = wave_ext < 8'(WAVE_SLOTS);
  assign coef_ok  = wave_ok && (in_degree <= 3'(MAX_DEGREE)) && (in_order <= 3'(MAX_DEGREE));

  // Coefficient memory: {sin_minus, cos_minus, sin_plus, cos_plus}
  logic             coef_we;
  logic [CA_W-1:0]  coef_waddr, coef_raddr;
  logic [127:0]     coef_wdata, coef_rdata;

  always_comb begin
    if (state == S_CLEAR) begin
      coef_we    = 1'b1;
      coef_waddr = clr_addr;
      coef_wdata = '0;
    end else begin
      coef_we    = s_xfer && in_func == FUNC_LOAD_COEF && coef_ok;
      coef_waddr = CA_W'(CA_W'(wave_ext[WIDX_W-1:0]) * CA_W'(NTERMS)
                   + CA_W'(in_degree) * CA_W'(NSIDE) + CA_W'(in_order));
      coef_wdata = {in_sin_minus, in_cos_minus, in_sin_plus, in_cos_plus};
    end
  end

  assign coef_raddr = CA_W'(CA_W'(w_idx) * CA_W'(NTERMS)
                      + CA_W'(n_idx) * CA_W'(NSIDE) + CA_W'(m_idx));

  ths_ram #(.WIDTH(128), .DEPTH(CDEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // Multiplier memory
  logic              mult_we;
  logic [WIDX_W-1:0] mult_waddr;
  logic [23:0]       mult_wdata, mult_rdata;

  always_comb begin
    if (state == S_CLEAR) begin
      mult_we    = clr_addr < CA_W'(WAVE_SLOTS);
      mult_waddr = clr_addr[WIDX_W-1:0];
      mult_wdata = '0;
    end else begin
      mult_we    = s_xfer && in_func == FUNC_SET_MULT && wave_ok;
      mult_waddr = wave_ext[WIDX_W-1:0];
      mult_wdata = in_mult;
    end
  end

  ths_ram #(.WIDTH(24), .DEPTH(WAVE_SLOTS)) u_mult_ram (
    .clk   (clk),
    .we    (mult_we),
    .waddr (mult_waddr),
    .wdata (mult_wdata),
    .raddr (w_idx),
    .rdata (mult_rdata)
  );

  // Per-wave sine and cosine: {cos, sin}, Q30
  logic               trig_we;
  logic signed [31:0] cos_clamped, sin_out, cos_out;
  logic [63:0]        trig_rdata;

  assign trig_we     = (state == S_TRIG) && (step == TS_STORE);
  assign cos_clamped = clamp_one(acc);

  // Fold the quarter-wave values into the quadrant given by the top phase bits
  always_comb begin
    case (theta[31:30])
      2'd0:    begin sin_out = sin_q;        cos_out = cos_clamped;  end
      2'd1:    begin sin_out = cos_clamped;  cos_out = -sin_q;       end
      2'd2:    begin sin_out = -sin_q;       cos_out = -cos_clamped; end
      default: begin sin_out = -cos_clamped; cos_out = sin_q;        end
    endcase
  end

  ths_ram #(.WIDTH(64), .DEPTH(WAVE_SLOTS)) u_trig_ram (
    .clk   (clk),
    .we    (trig_we),
    .waddr (w_idx),
    .wdata ({cos_out, sin_out}),
    .raddr (w_idx),
    .rdata (trig_rdata)
  );

  // Shared multiplier: operand select, product registered every cycle
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] mul_res;
  logic [2:0]         arg_sel;
  logic [3:0]         nib;
  logic signed [33:0] prod_q;

  assign arg_sel = 3'(step - 5'd2);
  assign nib     = mult_q[4*arg_sel +: 4];
  assign prod_q  = q30_trunc(prod);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_THETA: begin
        if (arg_sel < NUM_ARGS) begin
          mul_a = 34'($signed(nib));
          mul_b = $signed(phases[arg_sel]);
        end
      end
      S_TRIG: begin
        if (step == 5'd0) begin
          mul_a = 34'($signed({4'b0, theta[29:0]}));
          mul_b = $signed({2'b0, theta[29:0]});
        end else if (step == TS_SIN_X) begin
          mul_a = acc;
          mul_b = $signed({2'b0, theta[29:0]});
        end else begin
          mul_a = acc;
          mul_b = $signed(y_q);
        end
      end
      S_MAC: begin
        case (step)
          MS_P0:   begin mul_a = 34'(cpm); mul_b = cn_q; end
          MS_P1:   begin mul_a = 34'(spm); mul_b = sn_q; end
          MS_P2:   begin mul_a = 34'(sdf); mul_b = cn_q; end
          MS_P3:   begin mul_a = 34'(cdf); mul_b = sn_q; end
          default: begin mul_a = '0;       mul_b = '0;   end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_res;
  end

  // Output register
  logic out_load, last_term;
  logic [2:0] out_degree, out_order;
  logic signed [47:0] cnm_sum, snm_sum;

  assign last_term = (n_idx == 3'(MAX_DEGREE)) && (m_idx == 3'(MAX_DEGREE));
  assign out_load  = (state == S_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_degree <= n_idx;
      out_order  <= m_idx;
      cnm_sum    <= csum;
      snm_sum    <= (n_idx == 3'd0 || m_idx == 3'd0) ? '0 : ssum;
      m_tlast    <= last_term;
    end
  end

  assign m_tdata = {2'b0, snm_sum, cnm_sum, out_order, out_degree};

  // Main sequencer
  logic [7:0] cfg_ext;
  assign cfg_ext = 8'(waves_in_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      step     <= '0;
      w_cnt    <= '0;
      used_cnt <= '0;
      n_idx    <= '0;
      m_idx    <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          // sweep the coefficient and multiplier memories to zero
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CA_W'(CDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_xfer && in_func == FUNC_EVALUATE) begin
            used_cnt <= (cfg_ext > 8'(WAVE_SLOTS)) ? WCNT_W'(WAVE_SLOTS)
                                                   : WCNT_W'(waves_in_use);
            w_cnt    <= '0;
            n_idx    <= '0;
            m_idx    <= '0;
            step     <= '0;
            csum     <= '0;
            ssum     <= '0;
            if (cfg_ext == 8'd0) begin
              state <= S_EMIT;
            end else begin
              state <= S_THETA;
            end
          end
        end
        S_THETA: begin
          // one multiplier-times-phase product a cycle, accumulated from the product register
          if (step == 5'd1) begin
            mult_q <= mult_rdata;
            theta  <= '0;
          end else if (step >= 5'd3) begin
            theta <= theta + prod[31:0];
          end
          if (step == TH_LAST) begin
            step  <= '0;
            state <= S_TRIG;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_TRIG: begin
          if (step == TS_Y) begin
            y_q <= prod_q[31:0];
            acc <= sin_coef(3'd5);
          end else if (step == TS_SIN_END) begin
            sin_q <= clamp_one(prod_q);
            acc   <= cos_coef(3'd6);
          end else if (step > TS_Y && step < TS_SIN_X && step[0]) begin
            acc <= prod_q + sin_coef(3'((5'd11 - step) >> 1));
          end else if (step > TS_SIN_END && step < TS_STORE && step[0]) begin
            acc <= prod_q + cos_coef(3'((5'd25 - step) >> 1));
          end
          if (step == TS_STORE) begin
            step <= '0;
            if (w_cnt + 1'b1 < used_cnt) begin
              w_cnt <= w_cnt + 1'b1;
              state <= S_THETA;
            end else begin
              w_cnt <= '0;
              state <= S_MAC;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MAC: begin
          if (step != MS_SSUM) begin
            step <= step + 1'b1;
          end
          case (step)
            MS_LOAD: begin
              cpm  <= 33'($signed(coef_rdata[31:0]))  + 33'($signed(coef_rdata[95:64]));
              cdf  <= 33'($signed(coef_rdata[31:0]))  - 33'($signed(coef_rdata[95:64]));
              spm  <= 33'($signed(coef_rdata[63:32])) + 33'($signed(coef_rdata[127:96]));
              sdf  <= 33'($signed(coef_rdata[63:32])) - 33'($signed(coef_rdata[127:96]));
              sn_q <= $signed(trig_rdata[31:0]);
              cn_q <= $signed(trig_rdata[63:32]);
            end
            MS_P1: begin
              part <= prod_q;
            end
            MS_P2: begin
              csum <= sat48(50'(csum) + 50'(part) + 50'(prod_q));
            end
            MS_P3: begin
              part <= prod_q;
            end
            MS_SSUM: begin
              ssum <= sat48(50'(ssum) + 50'(part) - 50'(prod_q));
              step <= '0;
              if (w_cnt + 1'b1 < used_cnt) begin
                w_cnt <= w_cnt + 1'b1;
              end else begin
                w_cnt <= '0;
                state <= S_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
        S_EMIT: begin
          // hand the term to the output register, then advance degree and order
          if (out_load) begin
            csum <= '0;
            ssum <= '0;
            step <= '0;
            w_cnt <= '0;
            if (last_term) begin
              state <= S_IDLE;
            end else begin
              if (m_idx == 3'(MAX_DEGREE)) begin
                m_idx <= '0;
                n_idx <= n_idx + 1'b1;
              end else begin
                m_idx <= m_idx + 1'b1;
              end
              if (used_cnt != '0) begin
                state <= S_MAC;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Assertions
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_load && last_term |=> state == S_IDLE)
    else $error("sequencer did not return to idle after the final term");

  a_mac_wave_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> w_cnt < used_cnt)
    else $error("wave counter beyond waves in use during accumulation");

  a_sin_zero_edge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == 3'd0 || m_tdata[5:3] == 3'd0) |-> m_tdata[101:54] == '0)
    else $error("sine sum not zero at degree or order zero");

  a_trig_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_TRIG |-> step <= TS_STORE)
    else $error("trig step counter out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE && !(state == S_CLEAR))
    else $error("input taken while sequencer busy");

endmodule

// ----- dv/tb_tide_harmonic_synthesis_unit.sv -----
// Self-checking testbench for the tide harmonic synthesis unit.
`timescale 1ns / 100ps

module tb_tide_harmonic_synthesis_unit;
  import ths_pkg::*;

  localparam int SLOTS     = 16;
  localparam int TERMS     = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam longint Q_ONE  = 64'sd1073741824;
  localparam longint SUM_HI = 64'sd140737488355327;
  localparam longint SUM_LO = -64'sd140737488355328;

  // One input transfer, unpacked
  typedef struct {
    func_t              func;
    logic [3:0]         wave;
    logic [2:0]         degree;
    logic [2:0]         order;
    logic signed [31:0] cos_plus;
    logic signed [31:0] sin_plus;
    logic signed [31:0] cos_minus;
    logic signed [31:0] sin_minus;
    logic [23:0]        mults;
    logic [2:0]         angle_index;
    logic [31:0]        angle;
  } tide_item_t;

  // One expected correction term
  typedef struct {
    logic [2:0]  degree;
    logic [2:0]  order;
    logic [47:0] cnm;
    logic [47:0] snm;
    logic        last;
  } term_t;

  // Tide synthesis predictor and the queue of terms still to come
  class tide_scoreboard;
    int          coef_cp [SLOTS][TERMS];
    int          coef_sp [SLOTS][TERMS];
    int          coef_cm [SLOTS][TERMS];
    int          coef_sm [SLOTS][TERMS];
    logic [23:0] wave_mult [SLOTS];
    logic [31:0] arg_phase [6];
    int          waves_used;
    longint      sin_k [6];
    longint      cos_k [7];
    term_t       pending_terms [$];
    int          errors;

    function new();
      sin_k = '{1686629713, -693598668, 85569306, -5026995, 172272, -3864};
      cos_k = '{1073741824, -1324675879, 272375560, -22401992, 987048, -27060, 506};
      foreach (coef_cp[w, t]) begin
        coef_cp[w][t] = 0; coef_sp[w][t] = 0; coef_cm[w][t] = 0; coef_sm[w][t] = 0;
      end
      foreach (wave_mult[w]) wave_mult[w] = '0;
      foreach (arg_phase[i]) arg_phase[i] = '0;
      waves_used = 0;
      errors = 0;
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b) / Q_ONE;
    endfunction

    function longint clamp_unit(longint v);
      if (v > Q_ONE) return Q_ONE;
      if (v < -Q_ONE) return -Q_ONE;
      return v;
    endfunction

    function longint sat_sum(longint v);
      if (v > SUM_HI) return SUM_HI;
      if (v < SUM_LO) return SUM_LO;
      return v;
    endfunction

    // Doodson dot product, wrapping in whole turns
    function logic [31:0] doodson_phase(logic [23:0] packed_m);
      logic [31:0] th;
      longint      m;
      th = '0;
      for (int i = 0; i < 6; i++) begin
        m = longint'($signed(packed_m[4*i +: 4]));
        th = th + 32'(m * longint'(arg_phase[i]));
      end
      return th;
    endfunction

    function void wave_trig(logic [31:0] ph, output longint s, output longint c);
      longint x, y, acc, qs, qc;
      x = longint'(ph[29:0]);
      y = qmul(x, x);
      acc = sin_k[5];
      for (int i = 4; i >= 0; i--) acc = qmul(acc, y) + sin_k[i];
      qs = clamp_unit(qmul(acc, x));
      acc = cos_k[6];
      for (int i = 5; i >= 0; i--) acc = qmul(acc, y) + cos_k[i];
      qc = clamp_unit(acc);
      case (ph[31:30])
        2'd0: begin s = qs;  c = qc;  end
        2'd1: begin s = qc;  c = -qs; end
        2'd2: begin s = -qs; c = -qc; end
        default: begin s = -qc; c = qs; end
      endcase
    endfunction

    // Note an accepted input transfer and queue the terms it will cause
    function void note_input(tide_item_t it);
      longint sn [SLOTS], cn [SLOTS];
      longint csum, ssum, cp, sp, cm, sm;
      int     k;
      term_t  e;
      case (it.func)
        FUNC_LOAD_COEF: begin
          k = it.degree * 8 + it.order;
          coef_cp[it.wave][k] = it.cos_plus;
          coef_sp[it.wave][k] = it.sin_plus;
          coef_cm[it.wave][k] = it.cos_minus;
          coef_sm[it.wave][k] = it.sin_minus;
        end
        FUNC_SET_MULT: wave_mult[it.wave] = it.mults;
        FUNC_SET_PHASE: if (it.angle_index < NUM_ARGS) arg_phase[it.angle_index] = it.angle;
        default: begin
          for (int w = 0; w < waves_used; w++)
            wave_trig(doodson_phase(wave_mult[w]), sn[w], cn[w]);
          for (int t = 0; t < TERMS; t++) begin
            csum = 0;
            ssum = 0;
            for (int w = 0; w < waves_used; w++) begin
              cp = coef_cp[w][t]; sp = coef_sp[w][t];
              cm = coef_cm[w][t]; sm = coef_sm[w][t];
              csum = sat_sum(csum + qmul(cp + cm, cn[w]) + qmul(sp + sm, sn[w]));
              ssum = sat_sum(ssum + qmul(sp - sm, cn[w]) - qmul(cp - cm, sn[w]));
            end
            e.degree = 3'(t / 8);
            e.order  = 3'(t % 8);
            if (e.degree == 0 || e.order == 0) ssum = 0;
            e.cnm  = csum[47:0];
            e.snm  = ssum[47:0];
            e.last = (t == TERMS - 1);
            pending_terms.insert(pending_terms.size(), e);
          end
        end
      endcase
    endfunction

    function void set_waves(int v);
      waves_used = (v > SLOTS) ? SLOTS : v;
    endfunction

    // Check an accepted output transfer against the oldest expected term
    function void check_term(logic [OUT_DATA_W-1:0] d, logic l);
      term_t e;
      if (pending_terms.size() == 0) begin
        $display("%0t: unexpected term, expected none, actual %h last %b", $time, d, l);
        errors++;
        return;
      end
      e = pending_terms.pop_front();
      if (d[2:0] !== e.degree) begin
        $display("%0t: degree expected %0d actual %0d", $time, e.degree, d[2:0]);
        errors++;
      end
      if (d[5:3] !== e.order) begin
        $display("%0t: order expected %0d actual %0d", $time, e.order, d[5:3]);
        errors++;
      end
      if (d[53:6] !== e.cnm) begin
        $display("%0t: cnm (%0d,%0d) expected %h actual %h", $time, e.degree, e.order,
                 e.cnm, d[53:6]);
        errors++;
      end
      if (d[101:54] !== e.snm) begin
        $display("%0t: snm (%0d,%0d) expected %h actual %h", $time, e.degree, e.order,
                 e.snm, d[101:54]);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: tlast expected %b actual %b", $time, e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_W-1:0]      cfg_wr_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  tide_scoreboard sb;
  bit             quiet;      // no idling on either side
  int             idle_cycles;

  tide_harmonic_synthesis_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sender: optionally idle for a burst, then hold the transfer until accepted
  task automatic send_item(tide_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.func;
    s_tdata  <= {3'b000, it.angle, it.angle_index, it.mults, it.sin_minus, it.cos_minus,
                 it.sin_plus, it.cos_plus, it.order, it.degree, it.wave};
    do @(posedge clk); while (!s_tready);
    sb.note_input(it);
  endtask

  // Write the wave count once every queued term has drained
  task automatic write_waves(int v);
    s_tvalid <= 1'b0;
    while (sb.pending_terms.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_waves(v);
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return {2'($urandom_range(0, 3)), 30'h0000_0000};
      default: return $urandom;
    endcase
  endfunction

  function automatic tide_item_t blank_item(func_t f);
    tide_item_t it;
    it.func = f; it.wave = '0; it.degree = '0; it.order = '0;
    it.cos_plus = '0; it.sin_plus = '0; it.cos_minus = '0; it.sin_minus = '0;
    it.mults = '0; it.angle_index = '0; it.angle = '0;
    return it;
  endfunction

  function automatic tide_item_t coef_item(logic [3:0] w, logic [2:0] n, logic [2:0] m,
                                           logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
    tide_item_t it;
    it = blank_item(FUNC_LOAD_COEF);
    it.wave = w; it.degree = n; it.order = m;
    it.cos_plus = a; it.sin_plus = b; it.cos_minus = c; it.sin_minus = d;
    return it;
  endfunction

  function automatic tide_item_t mult_item(logic [3:0] w, logic [23:0] mv);
    tide_item_t it;
    it = blank_item(FUNC_SET_MULT);
    it.wave = w; it.mults = mv;
    return it;
  endfunction

  function automatic tide_item_t phase_item(logic [2:0] idx, logic [31:0] a);
    tide_item_t it;
    it = blank_item(FUNC_SET_PHASE);
    it.angle_index = idx; it.angle = a;
    return it;
  endfunction

  // Random item with every field filled so that unused bits also toggle
  function automatic tide_item_t random_item(int waves);
    tide_item_t it;
    int         pick;
    pick = $urandom_range(0, 99);
    it.func = (pick < 50) ? FUNC_LOAD_COEF : (pick < 70) ? FUNC_SET_MULT :
              (pick < 92) ? FUNC_SET_PHASE : FUNC_EVALUATE;
    // aim most table writes at waves that take part in the sum
    it.wave = ($urandom_range(0, 3) != 0 && waves > 0) ? 4'($urandom_range(0, waves - 1))
                                                       : 4'($urandom);
    it.degree      = 3'($urandom);
    it.order       = 3'($urandom);
    it.cos_plus    = pick_coef();
    it.sin_plus    = pick_coef();
    it.cos_minus   = pick_coef();
    it.sin_minus   = pick_coef();
    it.mults       = 24'($urandom);
    it.angle_index = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
    it.angle       = pick_angle();
    return it;
  endfunction

  // Receiver: check each output transfer, stall in bursts, watch for a hang
  initial begin
    int stall;
    stall       = 0;
    idle_cycles = 0;
    m_tready   <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_term(m_tdata, m_tlast);
      if (rst || (m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[tide_harmonic_synthesis_unit] ERROR");
        $finish;
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int waves_plan [6];
    sb = new();
    quiet        = 1'b0;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= FUNC_LOAD_COEF;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty sum first, then two waves at coefficient and phase extremes
    send_item(blank_item(FUNC_EVALUATE));
    send_item(coef_item(4'd0, 3'd0, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(coef_item(4'd0, 3'd7, 3'd7, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000));
    send_item(coef_item(4'd1, 3'd3, 3'd5, 32'h0001_0000, 32'hFFFF_0000,
                        32'h0000_8000, 32'h0002_0000));
    send_item(coef_item(4'd1, 3'd0, 3'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(coef_item(4'd15, 3'd7, 3'd0, 32'h1234_5678, 32'h8765_4321,
                        32'hDEAD_BEEF, 32'h0BAD_F00D));
    send_item(mult_item(4'd0, 24'h00_0001));
    send_item(mult_item(4'd1, 24'h87_F8_71));
    send_item(mult_item(4'd15, 24'hFF_FFFF));
    send_item(phase_item(3'd0, 32'h4000_0000));
    send_item(phase_item(3'd6, 32'hFFFF_FFFF));   // index above five: ignored
    send_item(phase_item(3'd7, 32'h1234_5678));   // index above five: ignored
    send_item(blank_item(FUNC_EVALUATE));         // no waves in use yet
    write_waves(2);
    send_item(blank_item(FUNC_EVALUATE));
    send_item(phase_item(3'd0, 32'h8000_0000));
    send_item(phase_item(3'd5, 32'hFFFF_FFFF));
    send_item(phase_item(3'd1, 32'hC000_0000));
    send_item(blank_item(FUNC_EVALUATE));
    send_item(phase_item(3'd0, 32'hFFFF_FFFF));
    send_item(phase_item(3'd2, 32'h0000_0000));
    send_item(blank_item(FUNC_EVALUATE));

    // Random phases, each under its own wave count; the last runs without idling
    waves_plan = '{16, $urandom_range(17, 31), 1, $urandom_range(0, 16), 31, 3};
    foreach (waves_plan[p]) begin
      write_waves(waves_plan[p]);
      if (p == 5) quiet = 1'b1;
      for (int i = 0; i < 45; i++) send_item(random_item(sb.waves_used));
      send_item(blank_item(FUNC_EVALUATE));
    end

    s_tvalid <= 1'b0;
    while (sb.pending_terms.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[tide_harmonic_synthesis_unit] OK");
    end else begin
      $display("[tide_harmonic_synthesis_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ths_pkg.sv
hdl/ths_ram.sv
hdl/tide_harmonic_synthesis_unit.sv
dv/tb_tide_harmonic_synthesis_unit.sv
